/* hdl/bba_pkg.sv */
// Shared widths, register indexes and control types for the buddy block allocator.
package bba_pkg;

  localparam int REQ_W     = 32;
  localparam int OFF_W     = 36;
  localparam int ORD_W     = 5;
  localparam int BBS_W     = 17;
  localparam int CFG_W     = 17;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_BLK_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_ORDER = 2'd1;

  localparam logic [BBS_W-1:0] BBS_RESET = 17'd128;
  localparam logic [ORD_W-1:0] TOP_RESET = 5'd10;

  // Control from the sequencer to the free map.
  typedef struct packed {
    logic             clear;  // rebuild map: only top order free at offset 0
    logic [ORD_W-1:0] top;    // effective top order for clear
    logic             take;   // mark order idx empty
    logic             put;    // mark order idx free at offset off
    logic [ORD_W-1:0] idx;
    logic [OFF_W-1:0] off;
  } map_ctl_t;

endpackage

/* hdl/bba_free_map.sv */
// Per-order free block map: one valid bit and one stored offset for each order.
module bba_free_map #(
  parameter int MAX_ORDER = 20
) (
  input  logic                     clk,
  input  bba_pkg::map_ctl_t        ctl,
  output logic [MAX_ORDER:0]       free_valid,
  output logic [bba_pkg::OFF_W-1:0] rd_off
);
  import bba_pkg::*;

  localparam int OW = $clog2(MAX_ORDER + 1);

  logic [OFF_W-1:0] offsets [MAX_ORDER+1];

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      free_valid <= {{MAX_ORDER{1'b0}}, 1'b1} << ctl.top[OW-1:0];
    end else if (ctl.take) begin
      free_valid[ctl.idx[OW-1:0]] <= 1'b0;
    end else if (ctl.put) begin
      free_valid[ctl.idx[OW-1:0]] <= 1'b1;
    end
  end

  // The top order slot is never written: a block there always sits at offset 0.
  always_ff @(posedge clk) begin
    if (ctl.put && !ctl.clear) begin
      offsets[ctl.idx[OW-1:0]] <= ctl.off;
    end
  end

  assign rd_off = offsets[ctl.idx[OW-1:0]];

endmodule

/* hdl/buddy_block_allocate.sv */
// Buddy block allocator, allocation side: request in, granted block offset out.
//
// Input channel in_valid/in_ready carries request_bytes; output channel
// out_valid/out_ready carries granted, user_offset and block_order, one
// result per request. The configuration port writes the block size
// (index 0) or top_order (index 1) on cfg_write_en; any such write rebuilds
// the free map with only the top order free at offset 0.
// One shared shifter/comparator/adder runs under a small sequencer. A request
// is loaded, the needed order is found (one shifted block size compare per
// order), the free orders are searched upward from it, the found block is
// split down to the needed order, and the result is posted. A failed
// request skips the split and posts a result with granted low.
// in_ready is high only while idle. The result waits in an output register,
// and the next request is taken while it waits; that request holds its
// result until the register frees up.
// Reset (rst, synchronous) sets the block size to 128, top_order to 10 and
// the free map to one free block at the top order.
module buddy_block_allocate #(
  parameter int MAX_ORDER    = 20,
  parameter int HEADER_BYTES = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write_en,
  input  logic [bba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bba_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bba_pkg::REQ_W-1:0]     request_bytes,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          granted,
  output logic [bba_pkg::OFF_W-1:0]     user_offset,
  output logic [bba_pkg::ORD_W-1:0]     block_order
);
  import bba_pkg::*;

  localparam int OW    = $clog2(MAX_ORDER + 1);
  localparam int SHW   = BBS_W + MAX_ORDER;
  localparam int XW    = REQ_W + 1;
  localparam int CMP_W = (SHW > XW) ? SHW : XW;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_NEED  = 3'd1;
  localparam logic [2:0] S_FIND  = 3'd2;
  localparam logic [2:0] S_SPLIT = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]       state;
  logic [BBS_W-1:0] blk_size;
  logic [ORD_W-1:0] top_order;
  logic [ORD_W-1:0] eff_top;
  logic [ORD_W-1:0] new_top;
  logic [BBS_W-1:0] eff_bbs;
  logic             cfg_hit;

  logic [ORD_W-1:0] k;
  logic [ORD_W-1:0] k_dec;
  logic [ORD_W-1:0] need;
  logic [SHW-1:0]   sh;
  logic [XW-1:0]    x;
  logic [OFF_W-1:0] cur;
  logic             res_granted;
  logic             fits;
  logic             load_out;

  map_ctl_t         map_ctl;
  logic [MAX_ORDER:0] free_valid;
  logic [OFF_W-1:0] rd_off;

  function automatic logic [ORD_W-1:0] clamp_top(input logic [ORD_W-1:0] t);
    return (int'(t) > MAX_ORDER) ? ORD_W'(MAX_ORDER) : t;
  endfunction

  assign eff_top = clamp_top(top_order);
  assign eff_bbs = (blk_size == '0) ? BBS_W'(1) : blk_size;
  assign cfg_hit = cfg_write_en &&
                   (cfg_index == CFG_BLK_SIZE || cfg_index == CFG_TOP_ORDER);
  assign new_top = (cfg_index == CFG_TOP_ORDER) ? clamp_top(cfg_data[ORD_W-1:0]) : eff_top;

  assign k_dec    = k - ORD_W'(1);
  assign fits     = CMP_W'(sh) >= CMP_W'(x);
  assign in_ready = (state == S_IDLE);
  assign load_out = (state == S_OUT) && (!out_valid || out_ready);

  always_comb begin
    map_ctl.clear = rst || cfg_hit;
    map_ctl.top   = rst ? clamp_top(TOP_RESET) : new_top;
    map_ctl.take  = (state == S_FIND) && free_valid[k[OW-1:0]];
    map_ctl.put   = (state == S_SPLIT);
    map_ctl.idx   = (state == S_SPLIT) ? k_dec : k;
    map_ctl.off   = cur;
  end

  bba_free_map #(
    .MAX_ORDER(MAX_ORDER)
  ) u_free_map (
    .clk       (clk),
    .ctl       (map_ctl),
    .free_valid(free_valid),
    .rd_off    (rd_off)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      blk_size  <= BBS_RESET;
      top_order <= TOP_RESET;
    end else if (cfg_write_en) begin
      if (cfg_index == CFG_BLK_SIZE) begin
        blk_size <= cfg_data[BBS_W-1:0];
      end else if (cfg_index == CFG_TOP_ORDER) begin
        top_order <= cfg_data[ORD_W-1:0];
      end
    end
  end

  // Sequencer: needed order, free order search, split down.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            x     <= {1'b0, request_bytes} + XW'(HEADER_BYTES);
            sh    <= SHW'(eff_bbs);
            k     <= '0;
            state <= S_NEED;
          end
        end
        S_NEED: begin
          // smallest k with block size << k covering the request plus header
          if (fits) begin
            need  <= k;
            state <= S_FIND;
          end else if (k == eff_top) begin
            res_granted <= 1'b0;
            state       <= S_OUT;
          end else begin
            k  <= k + ORD_W'(1);
            sh <= sh << 1;
          end
        end
        S_FIND: begin
          if (free_valid[k[OW-1:0]]) begin
            cur <= (k == eff_top) ? '0 : rd_off;
            if (k == need) begin
              res_granted <= 1'b1;
              state       <= S_OUT;
            end else begin
              state <= S_SPLIT;
            end
          end else if (k == eff_top) begin
            res_granted <= 1'b0;
            state       <= S_OUT;
          end else begin
            k  <= k + ORD_W'(1);
            sh <= sh << 1;
          end
        end
        S_SPLIT: begin
          // lower half stays free, carry on with the upper half
          k   <= k_dec;
          sh  <= sh >> 1;
          cur <= cur + OFF_W'(sh >> 1);
          if (k_dec == need) begin
            res_granted <= 1'b1;
            state       <= S_OUT;
          end
        end
        S_OUT: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      granted     <= res_granted;
      user_offset <= res_granted ? cur + OFF_W'(HEADER_BYTES) : '0;
      block_order <= res_granted ? need : '0;
    end
  end

endmodule

/* verif/tb.sv */
// Self-checking testbench for the buddy block allocator: directed and random allocation traffic.
`timescale 1ns / 1ps

module tb;
  import bba_pkg::*;

  localparam int MAX_ORD       = 20;
  localparam int HDR_BYTES     = 16;
  localparam int RANDOM_ITEMS  = 1500;
  localparam int SETTLE_CYCLES = 64;
  localparam int CYCLE_LIMIT   = 1000000;

  // Indexes past the register list; a write there must leave the map alone.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  localparam logic [OFF_W-1:0] OFF_MASK = {OFF_W{1'b1}};

  typedef struct packed {
    logic             ok;
    logic [OFF_W-1:0] off;
    logic [ORD_W-1:0] ord;
  } alloc_t;

  logic               clk;
  logic               rst;
  logic               cfg_write_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]   cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic [REQ_W-1:0]   request_bytes;
  logic               out_valid;
  logic               out_ready;
  logic               granted;
  logic [OFF_W-1:0]   user_offset;
  logic [ORD_W-1:0]   block_order;

  // Allocator shadow: registers and one free slot per order.
  logic [BBS_W-1:0]   bbs_reg;
  logic [ORD_W-1:0]   top_reg;
  bit                 free_ok [0:MAX_ORD];
  logic [OFF_W-1:0]   free_at [0:MAX_ORD];

  alloc_t             pending_allocs [$];
  int                 err_count;
  int                 cycle_count;
  int unsigned        hold_cnt;
  bit                 no_idle;

  buddy_block_allocate #(
    .MAX_ORDER   (MAX_ORD),
    .HEADER_BYTES(HDR_BYTES)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .request_bytes(request_bytes),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .granted      (granted),
    .user_offset  (user_offset),
    .block_order  (block_order)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int eff_top();
    return (top_reg > MAX_ORD) ? MAX_ORD : int'(top_reg);
  endfunction

  function automatic longint unsigned eff_bbs();
    return (bbs_reg == '0) ? 64'd1 : 64'(bbs_reg);
  endfunction

  function automatic void map_rebuild();
    for (int i = 0; i <= MAX_ORD; i++) begin
      free_ok[i] = 1'b0;
      free_at[i] = '0;
    end
    free_ok[eff_top()] = 1'b1;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    case (idx)
      CFG_BLK_SIZE: begin
        bbs_reg = data[BBS_W-1:0];
        map_rebuild();
      end
      CFG_TOP_ORDER: begin
        top_reg = data[ORD_W-1:0];
        map_rebuild();
      end
      default: ;
    endcase
  endfunction

  // Find the needed order, take the smallest free block at or above it and
  // split down, leaving each lower half free.
  function automatic alloc_t allocate_block(logic [REQ_W-1:0] bytes);
    alloc_t            r;
    longint unsigned   bbs;
    longint unsigned   x;
    longint unsigned   q;
    longint unsigned   cur;
    int                top;
    int                need;
    int                k;
    r    = '0;
    bbs  = eff_bbs();
    top  = eff_top();
    x    = 64'(bytes) + HDR_BYTES;
    q    = (x + bbs - 1) / bbs;
    need = 0;
    while (need < 63 && (64'd1 << need) < q) need++;
    if (need > top) return r;
    k = need;
    while (k <= top && !free_ok[k]) k++;
    if (k > top) return r;
    cur = 64'(free_at[k]);
    free_ok[k] = 1'b0;
    while (k > need) begin
      k--;
      free_ok[k] = 1'b1;
      free_at[k] = OFF_W'(cur);
      cur = (cur + (bbs << k)) & 64'(OFF_MASK);
    end
    r.ok  = 1'b1;
    r.off = OFF_W'(cur + HDR_BYTES);
    r.ord = ORD_W'(need);
    return r;
  endfunction

  function automatic int unsigned draw_gap();
    return no_idle ? 0 : $urandom_range(0, 11);
  endfunction

  // Mostly sizes near order boundaries of the current block size.
  function automatic logic [REQ_W-1:0] pick_request();
    longint unsigned bbs;
    longint unsigned hi;
    longint unsigned lo;
    longint unsigned pick;
    int              k;
    bbs = eff_bbs();
    case ($urandom_range(0, 9))
      0, 1: return $urandom;
      2, 3: return $urandom_range(0, 32'(bbs * 4));
      default: begin
        k  = $urandom_range(0, $urandom_range(0, eff_top() + 1));
        hi = bbs << k;
        lo = (k == 0) ? 64'd0 : (bbs << (k - 1));
        case ($urandom_range(0, 3))
          0:       pick = hi;
          1:       pick = lo + 1;
          2:       pick = hi + 1;
          default: pick = lo + 1 + (64'($urandom) % (hi - lo));
        endcase
        pick = (pick < HDR_BYTES) ? 64'd0 : pick - HDR_BYTES;
        if (pick > 64'hFFFF_FFFF) return $urandom;
        return pick[REQ_W-1:0];
      end
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= data;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    apply_reg(idx, data);
  endtask

  task automatic write_top(input int t);
    logic [CFG_W-1:0] d;
    d = CFG_W'($urandom);
    d[ORD_W-1:0] = ORD_W'(t);
    write_reg(CFG_TOP_ORDER, d);
  endtask

  task automatic send_request(input logic [REQ_W-1:0] bytes);
    int unsigned gap;
    gap = draw_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    request_bytes <= bytes;
    do @(posedge clk); while (!in_ready);
    pending_allocs.insert(pending_allocs.size(), allocate_block(bytes));
  endtask

  // Drop valid, wait for every result, then let the sequencer go quiet.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_allocs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    send_request(32'd0);
    send_request(32'd112);
    send_request(32'd113);
    send_request(32'd240);
    send_request(32'd241);
    send_request(32'd0);
    send_request(32'd131056);   // top block already split
    send_request(32'hFFFF_FFFF);
    send_request(32'd65520);
    drain();
  endtask

  task automatic test_spare_index();
    write_reg(CFG_SPARE_A, {CFG_W{1'b1}});
    write_reg(CFG_SPARE_B, '0);
    send_request(32'd65520);    // fails unless the map was wrongly rebuilt
    send_request(32'd0);
    drain();
  endtask

  task automatic test_zero_block_size();
    write_reg(CFG_BLK_SIZE, '0);
    write_top(20);
    send_request(32'd0);
    send_request(32'hFFFF_FFFF);
    send_request(32'd1048560);
    send_request(32'd1);
    drain();
  endtask

  task automatic test_top_clamp();
    write_reg(CFG_BLK_SIZE, CFG_W'(1));
    write_reg(CFG_TOP_ORDER, {CFG_W{1'b1}});
    send_request(32'd1048560);
    send_request(32'd0);
    drain();
    write_top(21);
    send_request(32'd1048561);
    drain();
  endtask

  task automatic test_top_zero();
    write_reg(CFG_BLK_SIZE, CFG_W'(65536));
    write_top(0);
    send_request(32'd65520);
    send_request(32'd0);
    drain();
    write_top(0);
    send_request(32'd65521);
    drain();
  endtask

  task automatic test_wide_offsets();
    write_reg(CFG_BLK_SIZE, {CFG_W{1'b1}});
    write_top(20);
    send_request(32'd0);
    send_request(32'd0);
    send_request(32'hFFFF_FFFF);
    send_request(32'd0);
    drain();
  endtask

  task automatic random_config();
    int          which;
    int unsigned bbs;
    int          t;
    which = $urandom_range(0, 3);
    case ($urandom_range(0, 7))
      0:       bbs = 0;
      1:       bbs = 1;
      2:       bbs = 131071;
      3:       bbs = 65536;
      4:       bbs = $urandom_range(2, 200);
      5:       bbs = 128;
      default: bbs = $urandom_range(1, 131071);
    endcase
    case ($urandom_range(0, 5))
      0:       t = 0;
      1:       t = 20;
      2:       t = $urandom_range(21, 31);
      default: t = $urandom_range(0, 20);
    endcase
    if (which != 1) write_reg(CFG_BLK_SIZE, CFG_W'(bbs));
    if (which != 0) write_top(t);
    if ($urandom_range(0, 7) == 0)
      write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, CFG_W'($urandom));
  endtask

  task automatic test_random_traffic();
    int sent;
    int batch;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      random_config();
      no_idle = ($urandom_range(0, 4) == 0);
      batch   = $urandom_range(4, 40);
      repeat (batch) send_request(pick_request());
      sent += batch;
      drain();
    end
    no_idle = 1'b0;
  endtask

  function automatic void note_mismatch(string field, logic [63:0] want, logic [63:0] got);
    err_count++;
    $display("%0t: %s expected 0x%0h actual 0x%0h", $time, field, want, got);
  endfunction

  // Check each result transfer and pace out_ready.
  always @(posedge clk) begin
    alloc_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_allocs.size() == 0) begin
          note_mismatch("unexpected result, granted", 64'd0, 64'(granted));
        end else begin
          want = pending_allocs.pop_front();
          if (granted !== want.ok)
            note_mismatch("granted", 64'(want.ok), 64'(granted));
          if (user_offset !== want.off)
            note_mismatch("user_offset", 64'(want.off), 64'(user_offset));
          if (block_order !== want.ord)
            note_mismatch("block_order", 64'(want.ord), 64'(block_order));
        end
        hold_cnt = draw_gap();
        if (hold_cnt != 0) out_ready <= 1'b0;
      end else if (!out_ready) begin
        hold_cnt--;
        if (hold_cnt == 0) out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    err_count     = 0;
    cycle_count   = 0;
    hold_cnt      = 0;
    no_idle       = 1'b0;
    rst           <= 1'b1;
    cfg_write_en  <= 1'b0;
    cfg_index     <= CFG_BLK_SIZE;
    cfg_data      <= '0;
    in_valid      <= 1'b0;
    request_bytes <= '0;
    out_ready     <= 1'b1;
    bbs_reg       = BBS_RESET;
    top_reg       = TOP_RESET;
    map_rebuild();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_spare_index();
    test_zero_block_size();
    test_top_clamp();
    test_top_zero();
    test_wide_offsets();
    test_random_traffic();

    if (err_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
